### sv/bmhq_pkg.sv
// Shared types and codes for the binary max heap queue.
`default_nettype none
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_OUT_W = 9;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  // command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cell_cmd_t;

endpackage
`default_nettype wire

### sv/bmhq_cell.sv
// One slot of the sorted key row: holds one key, shifts or inserts with its neighbors.
`default_nettype none
module bmhq_cell #(
  parameter int CNT_W = 9,
  parameter int IDX = 0
) (
  input  wire                       clk,
  input  wire bmhq_pkg::cell_cmd_t  cmd,
  input  wire [CNT_W-1:0]           count,
  input  wire                       left_go,
  input  wire bmhq_pkg::key_t       left_val,
  input  wire bmhq_pkg::key_t       right_val,
  output logic                      go,
  output bmhq_pkg::key_t            val
);
  import bmhq_pkg::*;

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  key_t val_r;
  key_t val_nxt;
  logic occ;

  // slot holds a key when the count exceeds its index; go: new key lands at or before this slot
  assign occ = (count > IDX_C);
  assign go  = !occ || (cmd.key > val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.push && go) begin
      val_nxt = left_go ? left_val : cmd.key;
    end else if (cmd.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

### sv/binary_max_heap_queue_top.sv
// Top level of the max priority queue: a row of key cells kept sorted, plus count and result word.
//
// Max priority queue of signed 32-bit keys, up to CAPACITY of them. Each input word
// pushes a key or pops the largest; every request gives one result word with the new
// maximum (zero when empty), a non-empty flag, the count and an error code (pop on empty,
// push on full; neither changes the queue). Keys sit in a row of CAPACITY cells kept in
// descending order; on a push every cell compares against the key and shifts toward the
// tail in the same cycle, on a pop every cell takes its right neighbor. An accepted word
// gives its result word on the next cycle, so one word per cycle is sustained while the
// output side takes results; a result that is held stalls the input.
`default_nettype none
module binary_max_heap_queue_top #(
  parameter int CAPACITY = 256
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_req_type,
  input  wire bmhq_pkg::key_t              in_key,
  output logic                             out_valid,
  input  wire                              out_stall,
  output bmhq_pkg::key_t                   out_top_key,
  output logic                             out_top_valid,
  output logic [bmhq_pkg::CNT_OUT_W-1:0]   out_entry_count,
  output logic [1:0]                       out_error_code
);
  import bmhq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  err_t             err_r, err_nxt;
  logic             accept;
  cell_cmd_t        cmd;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  logic go   [CAPACITY];
  key_t vals [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.push      = 1'b0;
    cmd.pop       = 1'b0;
    cmd.key       = in_key;
    count_nxt     = count_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
      err_nxt       = ERR_NONE;
      if (req_t'(in_req_type) == REQ_PUSH) begin
        if (count_r >= CAP_C) begin
          err_nxt = ERR_FULL;
        end else begin
          cmd.push  = 1'b1;
          count_nxt = count_r + ONE_C;
        end
      end else begin
        if (count_r == '0) begin
          err_nxt = ERR_EMPTY;
        end else begin
          cmd.pop   = 1'b1;
          count_nxt = count_r - ONE_C;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      err_r       <= ERR_NONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic lgo;
    key_t lval;
    key_t rval;
    if (i == 0) begin : g_first
      assign lgo  = 1'b0;
      assign lval = vals[0];
    end else begin : g_mid
      assign lgo  = go[i-1];
      assign lval = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rval = vals[i];
    end else begin : g_body
      assign rval = vals[i+1];
    end
    bmhq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count_r),
      .left_go   (lgo),
      .left_val  (lval),
      .right_val (rval),
      .go        (go[i]),
      .val       (vals[i])
    );
  end

  assign count_ext       = {{CNT_OUT_W{1'b0}}, count_r};
  assign out_valid       = out_valid_r;
  assign out_top_valid   = (count_r != '0);
  assign out_top_key     = out_top_valid ? vals[0] : '0;
  assign out_entry_count = count_ext[CNT_OUT_W-1:0];
  assign out_error_code  = err_r;

endmodule
`default_nettype wire

### sv/bmhq_chk.sv
// Port-level checks for the max priority queue, bound to the top level.
`default_nettype none
module bmhq_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_top_key,
  input wire        out_top_valid,
  input wire [8:0]  out_entry_count,
  input wire [1:0]  out_error_code
);
  import bmhq_pkg::*;

  a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word produced no result word");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_empty_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_top_valid |-> out_top_key == '0 && out_entry_count == '0)
    else $error("empty queue reports a key or count");

  a_empty_error_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code == ERR_EMPTY |-> !out_top_valid)
    else $error("pop-on-empty error with keys held");

  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_top_key) && $stable(out_error_code))
    else $error("held result changed");

endmodule

bind binary_max_heap_queue_top bmhq_chk u_bmhq_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_top_key     (out_top_key),
  .out_top_valid   (out_top_valid),
  .out_entry_count (out_entry_count),
  .out_error_code  (out_error_code)
);
`default_nettype wire
